// ===== hw/rtl/i2cbm_pkg.sv =====
// Shared types, codes and helpers for the I2C bit-level master.
package i2cbm_pkg;

  typedef enum logic [2:0] {
    CMD_IDLE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_WRITE   = 3'd3,
    CMD_WAITACK = 3'd4,
    CMD_READ    = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    REG_HALF_PERIOD = 2'd0,
    REG_START_STOP  = 2'd1,
    REG_ACK_TIMEOUT = 2'd2
  } reg_idx_e;

  localparam logic [2:0] PH_0 = 3'd0;
  localparam logic [2:0] PH_1 = 3'd1;
  localparam logic [2:0] PH_2 = 3'd2;
  localparam logic [2:0] PH_3 = 3'd3;
  localparam logic [2:0] PH_4 = 3'd4;

  localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;
  localparam logic [15:0] RST_HALF_PERIOD = 16'd2;
  localparam logic [15:0] RST_START_STOP  = 16'd4;
  localparam logic [15:0] RST_ACK_TIMEOUT = 16'd250;

  typedef struct packed {
    logic [15:0] half_period;
    logic [15:0] start_stop;
    logic [15:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       drv;
    logic       busy;
    logic       done;
    logic       err;
    logic [7:0] rdata;
  } res_t;

  // zero delay counts as one tick
  function automatic logic [15:0] load_delay(input logic [15:0] n);
    return (n == 16'd0) ? 16'd1 : n;
  endfunction

endpackage

// ===== hw/rtl/i2cbm_seq.sv =====
// Command sequencer: bit-level state and next-word computation.
module i2cbm_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [2:0]        mode_i,
  input  logic [7:0]        write_data_i,
  input  logic              send_ack_i,
  input  logic              sda_in_i,
  input  i2cbm_pkg::cfg_t   cfg_i,
  output i2cbm_pkg::res_t   res_o
);
  import i2cbm_pkg::*;

  cmd_e        cmd_q, cmd_d;
  logic [2:0]  phase_q, phase_d;
  logic [3:0]  bit_idx_q, bit_idx_d;
  logic [3:0]  bit_inc;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] delay_q, delay_d;
  logic [15:0] tout_q, tout_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        drv_q, drv_d;
  logic        ack_choice_q, ack_choice_d;
  logic        err_q, err_d;
  logic [7:0]  read_q, read_d;
  logic        fin;

  assign bit_inc = bit_idx_q + 4'd1;

  always_comb begin
    cmd_d        = cmd_q;
    phase_d      = phase_q;
    bit_idx_d    = bit_idx_q;
    shift_d      = shift_q;
    delay_d      = delay_q;
    tout_d       = tout_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    drv_d        = drv_q;
    ack_choice_d = ack_choice_q;
    err_d        = err_q;
    read_d       = read_q;
    fin          = 1'b0;

    if (cmd_q != CMD_IDLE) begin
      if (cmd_q == CMD_WAITACK && phase_q == PH_2) begin
        if (!sda_in_i) begin
          scl_d = 1'b0; sda_d = 1'b1; drv_d = 1'b0;
          fin   = 1'b1;
        end else if (tout_q >= cfg_i.ack_timeout) begin
          // timed out: run a stop
          err_d   = 1'b1;
          cmd_d   = CMD_STOP;
          phase_d = PH_0;
          scl_d = 1'b1; sda_d = 1'b0; drv_d = 1'b1;
          delay_d = load_delay(cfg_i.start_stop);
        end else begin
          tout_d = tout_q + 16'd1;
        end
      end else if (delay_q > 16'd1) begin
        delay_d = delay_q - 16'd1;
      end else begin
        delay_d = '0;
        case (cmd_q)
          CMD_START: begin
            if (phase_q == PH_0) begin
              scl_d = 1'b1; sda_d = 1'b0; drv_d = 1'b1;
              delay_d = load_delay(cfg_i.start_stop);
              phase_d = PH_1;
            end else begin
              scl_d = 1'b0; sda_d = 1'b0; drv_d = 1'b1;
              fin   = 1'b1;
            end
          end
          CMD_STOP: begin
            if (phase_q == PH_0) begin
              scl_d = 1'b1; sda_d = 1'b1; drv_d = 1'b1;
              delay_d = load_delay(cfg_i.start_stop);
              phase_d = PH_1;
            end else begin
              fin = 1'b1;
            end
          end
          CMD_WRITE: begin
            if (phase_q == PH_0) begin
              scl_d = 1'b1; drv_d = 1'b1;
              delay_d = load_delay(cfg_i.half_period);
              phase_d = PH_1;
            end else if (phase_q == PH_1) begin
              scl_d = 1'b0; drv_d = 1'b1;
              delay_d = load_delay(cfg_i.half_period);
              phase_d = PH_2;
            end else begin
              bit_idx_d = bit_inc;
              if (bit_inc >= BITS_PER_BYTE) begin
                fin = 1'b1;
              end else begin
                scl_d = 1'b0; sda_d = shift_q[7]; drv_d = 1'b1;
                shift_d = {shift_q[6:0], 1'b0};
                delay_d = load_delay(cfg_i.half_period);
                phase_d = PH_0;
              end
            end
          end
          CMD_WAITACK: begin
            scl_d = 1'b1; sda_d = 1'b1; drv_d = 1'b0;
            tout_d  = '0;
            phase_d = PH_2;
          end
          CMD_READ: begin
            case (phase_q)
              PH_0: begin
                scl_d = 1'b1; sda_d = 1'b1; drv_d = 1'b0;
                shift_d = {shift_q[6:0], sda_in_i};
                delay_d = 16'd1;
                phase_d = PH_1;
              end
              PH_1: begin
                bit_idx_d = bit_inc;
                if (bit_inc < BITS_PER_BYTE) begin
                  scl_d = 1'b0; sda_d = 1'b1; drv_d = 1'b0;
                  delay_d = load_delay(cfg_i.half_period);
                  phase_d = PH_0;
                end else begin
                  read_d = shift_q;
                  scl_d = 1'b0; sda_d = !ack_choice_q; drv_d = 1'b1;
                  delay_d = load_delay(cfg_i.half_period);
                  phase_d = PH_2;
                end
              end
              PH_2: begin
                scl_d = 1'b1; drv_d = 1'b1;
                delay_d = load_delay(cfg_i.half_period);
                phase_d = PH_3;
              end
              PH_3: begin
                scl_d = 1'b0; drv_d = 1'b1;
                if (!ack_choice_q) begin
                  fin = 1'b1;
                end else begin
                  delay_d = load_delay(cfg_i.half_period);
                  phase_d = PH_4;
                end
              end
              default: fin = 1'b1;
            endcase
          end
          default: fin = 1'b1;
        endcase
      end
      if (fin) begin
        cmd_d   = CMD_IDLE;
        phase_d = PH_0;
        delay_d = '0;
      end
    end else begin
      case (mode_i)
        CMD_START: begin
          cmd_d = CMD_START; phase_d = PH_0; bit_idx_d = '0; tout_d = '0;
          scl_d = 1'b1; sda_d = 1'b1; drv_d = 1'b1;
          delay_d = load_delay(cfg_i.start_stop);
        end
        CMD_STOP: begin
          cmd_d = CMD_STOP; phase_d = PH_0; bit_idx_d = '0; tout_d = '0;
          scl_d = 1'b1; sda_d = 1'b0; drv_d = 1'b1;
          delay_d = load_delay(cfg_i.start_stop);
        end
        CMD_WRITE: begin
          cmd_d = CMD_WRITE; phase_d = PH_0; bit_idx_d = '0; tout_d = '0;
          scl_d = 1'b0; sda_d = write_data_i[7]; drv_d = 1'b1;
          shift_d = {write_data_i[6:0], 1'b0};
          delay_d = load_delay(cfg_i.half_period);
        end
        CMD_WAITACK: begin
          cmd_d = CMD_WAITACK; phase_d = PH_0; bit_idx_d = '0; tout_d = '0;
          err_d = 1'b0;
          sda_d = 1'b1; drv_d = 1'b0;
          delay_d = 16'd1;
        end
        CMD_READ: begin
          cmd_d = CMD_READ; phase_d = PH_0; bit_idx_d = '0; tout_d = '0;
          ack_choice_d = send_ack_i;
          shift_d = '0;
          scl_d = 1'b0; sda_d = 1'b1; drv_d = 1'b0;
          delay_d = load_delay(cfg_i.half_period);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q        <= CMD_IDLE;
      phase_q      <= PH_0;
      bit_idx_q    <= '0;
      shift_q      <= '0;
      delay_q      <= '0;
      tout_q       <= '0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      drv_q        <= 1'b1;
      ack_choice_q <= 1'b0;
      err_q        <= 1'b0;
      read_q       <= '0;
    end else if (step_i) begin
      cmd_q        <= cmd_d;
      phase_q      <= phase_d;
      bit_idx_q    <= bit_idx_d;
      shift_q      <= shift_d;
      delay_q      <= delay_d;
      tout_q       <= tout_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      drv_q        <= drv_d;
      ack_choice_q <= ack_choice_d;
      err_q        <= err_d;
      read_q       <= read_d;
    end
  end

  always_comb begin
    res_o.scl   = scl_d;
    res_o.sda   = sda_d;
    res_o.drv   = drv_d;
    res_o.busy  = (cmd_d != CMD_IDLE);
    res_o.done  = fin;
    res_o.err   = err_d;
    res_o.rdata = read_d;
  end

endmodule

// ===== hw/rtl/i2c_bit_level_master_core.sv =====
// I2C bit-level master: config registers, sequencer and two-entry output buffer.
// An accepted word's result is registered into the free entry of the output buffer.
// Throughput: one input word per cycle while the skid entry is empty; one tick per word.
// The two-entry output buffer keeps input ready while one result waits to be taken.
// Reset (async, active low): idle, SCL/SDA high and driven, error and read byte clear,
// registers back to half period 2, start/stop 4, ack timeout 250; no results pending.
module i2c_bit_level_master_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  write_data_i,
  input  logic        send_ack_i,
  input  logic        sda_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        scl_out_o,
  output logic        sda_out_o,
  output logic        sda_drive_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic        ack_error_o,
  output logic [7:0]  read_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import i2cbm_pkg::*;

  cfg_t cfg_q;
  res_t res;
  res_t out_q, skid_q;
  logic out_vld_q, skid_vld_q;
  logic in_fire, out_fire;

  assign in_ready_o = !skid_vld_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_vld_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period <= RST_HALF_PERIOD;
      cfg_q.start_stop  <= RST_START_STOP;
      cfg_q.ack_timeout <= RST_ACK_TIMEOUT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HALF_PERIOD: cfg_q.half_period <= cfg_data_i;
        REG_START_STOP:  cfg_q.start_stop  <= cfg_data_i;
        REG_ACK_TIMEOUT: cfg_q.ack_timeout <= cfg_data_i;
        default: ;
      endcase
    end
  end

  i2cbm_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (in_fire),
    .mode_i       (mode_i),
    .write_data_i (write_data_i),
    .send_ack_i   (send_ack_i),
    .sda_in_i     (sda_in_i),
    .cfg_i        (cfg_q),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_fire) begin
        skid_vld_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_vld_q || out_fire) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (!out_vld_q || out_fire) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign scl_out_o   = out_q.scl;
  assign sda_out_o   = out_q.sda;
  assign sda_drive_o = out_q.drv;
  assign busy_res_o  = out_q.busy;
  assign done_res_o  = out_q.done;
  assign ack_error_o = out_q.err;
  assign read_data_o = out_q.rdata;

endmodule

// ===== hw/rtl/i2cbm_chk.sv =====
// Port-level checker for the I2C bit-level master, bound to the top level.
module i2cbm_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        scl_out_o,
  input logic        sda_out_o,
  input logic        sda_drive_o,
  input logic        busy_res_o,
  input logic        done_res_o,
  input logic        ack_error_o,
  input logic [7:0]  read_data_o
);

  // a finishing word never reports busy
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("done with busy set");

  // released SDA always reads back high
  a_release_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sda_drive_o |-> sda_out_o)
    else $error("SDA released but low");

  // empty output buffer must take input
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // offered input word stays up until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i)
    else $error("input word withdrawn");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o)
      && $stable(scl_out_o) && $stable(ack_error_o) && $stable(done_res_o))
    else $error("stalled result word changed");

endmodule

bind i2c_bit_level_master_core i2cbm_chk u_i2cbm_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .scl_out_o   (scl_out_o),
  .sda_out_o   (sda_out_o),
  .sda_drive_o (sda_drive_o),
  .busy_res_o  (busy_res_o),
  .done_res_o  (done_res_o),
  .ack_error_o (ack_error_o),
  .read_data_o (read_data_o)
);

// ===== test/tb_i2c_bit_level_master_core.sv =====
// Testbench for i2c_bit_level_master_core: line-level prediction with random handshakes.
module tb_i2c_bit_level_master_core;
  import i2cbm_pkg::*;

  localparam logic [2:0] MODE_TICK   = CMD_IDLE;
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam logic [1:0] REG_UNUSED  = 2'd3;
  localparam int NEVER_ACK    = 1000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_REPORTS  = 10;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  mode_i;
  logic [7:0]  write_data_i;
  logic        send_ack_i;
  logic        sda_in_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        scl_out_o;
  logic        sda_out_o;
  logic        sda_drive_o;
  logic        busy_res_o;
  logic        done_res_o;
  logic        ack_error_o;
  logic [7:0]  read_data_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  i2c_bit_level_master_core DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted block state
  cmd_e       cur_cmd;
  logic [2:0] ph;
  logic [3:0] bidx;
  logic [7:0] shreg;
  logic [15:0] dly;
  logic [15:0] tmo;
  logic       p_scl, p_sda, p_drv;
  logic       ack_sel;
  logic       err;
  logic [7:0] rd_byte;
  cfg_t       timing;

  res_t line_status_q[$];
  int   mismatch_cnt = 0;
  int   words_sent = 0;
  int   src_idle_pct = 0;
  int   snk_idle_pct = 0;
  int   stall_cycles = 0;
  logic hold_tog = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  function automatic logic [15:0] ticks_or_one(input logic [15:0] n);
    return (n == 16'd0) ? 16'd1 : n;
  endfunction

  function automatic void set_lines(input logic scl, input logic sda, input logic drv);
    p_scl = scl;
    p_sda = sda;
    p_drv = drv;
  endfunction

  function automatic void begin_stop();
    cur_cmd = CMD_STOP;
    ph = PH_0;
    set_lines(1'b1, 1'b0, 1'b1);
    dly = ticks_or_one(timing.start_stop);
  endfunction

  function automatic void reset_model();
    timing = '{half_period: RST_HALF_PERIOD, start_stop: RST_START_STOP,
               ack_timeout: RST_ACK_TIMEOUT};
    cur_cmd = CMD_IDLE;
    ph = PH_0;
    bidx = '0;
    shreg = '0;
    dly = '0;
    tmo = '0;
    set_lines(1'b1, 1'b1, 1'b1);
    ack_sel = 1'b0;
    err = 1'b0;
    rd_byte = '0;
  endfunction

  // one tick of the running command; 1 when it finishes
  function automatic bit advance_cmd(input logic sda_s);
    if (cur_cmd == CMD_WAITACK && ph == PH_2) begin
      if (!sda_s) begin
        set_lines(1'b0, 1'b1, 1'b0);
        return 1'b1;
      end
      if (tmo >= timing.ack_timeout) begin
        err = 1'b1;
        begin_stop();
        return 1'b0;
      end
      tmo++;
      return 1'b0;
    end
    if (dly > 16'd1) begin
      dly--;
      return 1'b0;
    end
    dly = '0;
    case (cur_cmd)
      CMD_START: begin
        if (ph == PH_0) begin
          set_lines(1'b1, 1'b0, 1'b1);
          dly = ticks_or_one(timing.start_stop);
          ph = PH_1;
          return 1'b0;
        end
        set_lines(1'b0, 1'b0, 1'b1);
        return 1'b1;
      end
      CMD_STOP: begin
        if (ph == PH_0) begin
          set_lines(1'b1, 1'b1, 1'b1);
          dly = ticks_or_one(timing.start_stop);
          ph = PH_1;
          return 1'b0;
        end
        return 1'b1;
      end
      CMD_WRITE: begin
        if (ph == PH_0) begin
          set_lines(1'b1, p_sda, 1'b1);
          dly = ticks_or_one(timing.half_period);
          ph = PH_1;
          return 1'b0;
        end
        if (ph == PH_1) begin
          set_lines(1'b0, p_sda, 1'b1);
          dly = ticks_or_one(timing.half_period);
          ph = PH_2;
          return 1'b0;
        end
        bidx++;
        if (bidx >= BITS_PER_BYTE) return 1'b1;
        set_lines(1'b0, shreg[7], 1'b1);
        shreg = shreg << 1;
        dly = ticks_or_one(timing.half_period);
        ph = PH_0;
        return 1'b0;
      end
      CMD_WAITACK: begin
        set_lines(1'b1, 1'b1, 1'b0);
        tmo = '0;
        ph = PH_2;
        return 1'b0;
      end
      CMD_READ: begin
        case (ph)
          PH_0: begin
            set_lines(1'b1, 1'b1, 1'b0);
            shreg = {shreg[6:0], sda_s};
            dly = 16'd1;
            ph = PH_1;
            return 1'b0;
          end
          PH_1: begin
            bidx++;
            if (bidx < BITS_PER_BYTE) begin
              set_lines(1'b0, 1'b1, 1'b0);
              dly = ticks_or_one(timing.half_period);
              ph = PH_0;
              return 1'b0;
            end
            rd_byte = shreg;
            set_lines(1'b0, !ack_sel, 1'b1);
            dly = ticks_or_one(timing.half_period);
            ph = PH_2;
            return 1'b0;
          end
          PH_2: begin
            set_lines(1'b1, p_sda, 1'b1);
            dly = ticks_or_one(timing.half_period);
            ph = PH_3;
            return 1'b0;
          end
          PH_3: begin
            set_lines(1'b0, p_sda, 1'b1);
            if (!ack_sel) return 1'b1;
            dly = ticks_or_one(timing.half_period);
            ph = PH_4;
            return 1'b0;
          end
          default: return 1'b1;
        endcase
      end
      default: return 1'b1;
    endcase
    return 1'b1;
  endfunction

  function automatic res_t predict_lines(input logic [2:0] m, input logic [7:0] wd,
                                         input logic sa, input logic sda_s);
    res_t r;
    bit   fin;
    fin = 1'b0;
    if (cur_cmd != CMD_IDLE) begin
      if (advance_cmd(sda_s)) begin
        fin = 1'b1;
        cur_cmd = CMD_IDLE;
        ph = PH_0;
        dly = '0;
      end
    end else if (m >= CMD_START && m <= CMD_READ) begin
      cur_cmd = cmd_e'(m);
      ph = PH_0;
      bidx = '0;
      tmo = '0;
      case (cmd_e'(m))
        CMD_START: begin
          set_lines(1'b1, 1'b1, 1'b1);
          dly = ticks_or_one(timing.start_stop);
        end
        CMD_STOP: begin_stop();
        CMD_WRITE: begin
          set_lines(1'b0, wd[7], 1'b1);
          shreg = wd << 1;
          dly = ticks_or_one(timing.half_period);
        end
        CMD_WAITACK: begin
          err = 1'b0;
          set_lines(p_scl, 1'b1, 1'b0);
          dly = 16'd1;
        end
        default: begin
          ack_sel = sa;
          shreg = '0;
          set_lines(1'b0, 1'b1, 1'b0);
          dly = ticks_or_one(timing.half_period);
        end
      endcase
    end
    r.scl   = p_scl;
    r.sda   = p_sda;
    r.drv   = p_drv;
    r.busy  = (cur_cmd != CMD_IDLE);
    r.done  = fin;
    r.err   = err;
    r.rdata = rd_byte;
    return r;
  endfunction

  function automatic string fmt_lines(input res_t r);
    return $sformatf("scl=%0b sda=%0b drv=%0b busy=%0b done=%0b err=%0b rd=%02h",
                     r.scl, r.sda, r.drv, r.busy, r.done, r.err, r.rdata);
  endfunction

  // receiver: random ready, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    res_t act;
    res_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      act = {scl_out_o, sda_out_o, sda_drive_o, busy_res_o, done_res_o, ack_error_o,
             read_data_o};
      if (line_status_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected word: %s", fmt_lines(act));
      end else begin
        exp_r = line_status_q.pop_front();
        if (act !== exp_r) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("mismatch expected: %s", fmt_lines(exp_r));
            $display("         actual:   %s", fmt_lines(act));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("i2c_bit_level_master_core verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_word(input logic [2:0] m, input logic [7:0] wd, input logic sa,
                           input logic s);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= m;
    write_data_i <= wd;
    send_ack_i   <= sa;
    sda_in_i     <= s;
    do @(posedge clk_i); while (!in_ready_o);
    line_status_q.push_back(predict_lines(m, wd, sa, s));
    words_sent++;
  endtask

  // tick the running command to its end; ack_high = high SDA samples before the ack
  task automatic run_to_idle(input int ack_high);
    int         highs;
    logic       s;
    logic [2:0] m;
    highs = 0;
    while (cur_cmd != CMD_IDLE) begin
      m = MODE_TICK;
      if ($urandom_range(9) == 0) m = 3'($urandom_range(7));
      if (cur_cmd == CMD_WAITACK) begin
        s = (highs < ack_high);
        highs++;
      end else begin
        s = 1'($urandom_range(1));
      end
      send_word(m, 8'($urandom), 1'($urandom_range(1)), s);
    end
  endtask

  task automatic do_cmd(input cmd_e c, input logic [7:0] wd, input logic sa,
                        input int ack_high);
    send_word(c, wd, sa, 1'($urandom_range(1)));
    run_to_idle(ack_high);
  endtask

  task automatic set_timing(input logic [15:0] half, input logic [15:0] ss,
                            input logic [15:0] tout);
    logic [1:0]  idx [4];
    logic [15:0] val [4];
    idx = '{REG_HALF_PERIOD, REG_START_STOP, REG_ACK_TIMEOUT, REG_UNUSED};
    val = '{half, ss, tout, 16'($urandom)};
    in_valid_i <= 1'b0;
    while (line_status_q.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
      case (idx[i])
        REG_HALF_PERIOD: timing.half_period = val[i];
        REG_START_STOP:  timing.start_stop  = val[i];
        REG_ACK_TIMEOUT: timing.ack_timeout = val[i];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic i2c_transfer();
    int n_ops;
    int ack_high;
    do_cmd(CMD_START, 8'($urandom), 1'($urandom_range(1)), 0);
    n_ops = $urandom_range(1, 4);
    for (int i = 0; i < n_ops; i++) begin
      if ($urandom_range(99) < 30) ack_high = NEVER_ACK;
      else ack_high = $urandom_range(0, int'(timing.ack_timeout) + 1);
      if (i == 0 || $urandom_range(1) == 0) begin
        do_cmd(CMD_WRITE, 8'($urandom), 1'($urandom_range(1)), 0);
        do_cmd(CMD_WAITACK, 8'($urandom), 1'($urandom_range(1)), ack_high);
      end else begin
        do_cmd(CMD_READ, 8'($urandom), 1'($urandom_range(1)), 0);
      end
    end
    do_cmd(CMD_STOP, 8'($urandom), 1'($urandom_range(1)), 0);
  endtask

  // broken sequences: arbitrary modes, commands while busy
  task automatic noise_burst();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      send_word(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)),
                1'($urandom_range(1)));
      if ($urandom_range(1) == 0) run_to_idle($urandom_range(0, 4));
    end
    run_to_idle($urandom_range(0, 4));
  endtask

  task automatic test_basic_commands();
    send_word(MODE_TICK, 8'h00, 1'b0, 1'b0);
    send_word(MODE_SPARE6, 8'hFF, 1'b1, 1'b1);
    send_word(MODE_SPARE7, 8'h5A, 1'b0, 1'b1);
    do_cmd(CMD_START, 8'h00, 1'b0, 0);
    do_cmd(CMD_WRITE, 8'hFF, 1'b0, 0);
    do_cmd(CMD_WAITACK, 8'h00, 1'b0, 2);
    do_cmd(CMD_WRITE, 8'h00, 1'b1, 0);
    do_cmd(CMD_WAITACK, 8'h00, 1'b0, 0);
    do_cmd(CMD_WRITE, 8'hA5, 1'b0, 0);
    do_cmd(CMD_READ, 8'h00, 1'b1, 0);
    do_cmd(CMD_READ, 8'hFF, 1'b0, 0);
    do_cmd(CMD_WAITACK, 8'h00, 1'b0, NEVER_ACK);
    do_cmd(CMD_STOP, 8'h00, 1'b0, 0);
    do_cmd(CMD_WAITACK, 8'h00, 1'b0, 1);
  endtask

  task automatic test_min_timing();
    set_timing(16'd0, 16'd0, 16'd0);
    do_cmd(CMD_START, 8'h00, 1'b0, 0);
    do_cmd(CMD_WRITE, 8'($urandom), 1'b0, 0);
    do_cmd(CMD_WAITACK, 8'h00, 1'b0, NEVER_ACK);
    do_cmd(CMD_READ, 8'h00, 1'b1, 0);
    do_cmd(CMD_READ, 8'h00, 1'b0, 0);
    do_cmd(CMD_STOP, 8'h00, 1'b0, 0);
    set_timing(16'd1, 16'd1, 16'd1);
    do_cmd(CMD_START, 8'h00, 1'b0, 0);
    do_cmd(CMD_WRITE, 8'($urandom), 1'b0, 0);
    do_cmd(CMD_WAITACK, 8'h00, 1'b0, 1);
    do_cmd(CMD_WAITACK, 8'h00, 1'b0, 2);
    do_cmd(CMD_READ, 8'h00, 1'b1, 0);
    do_cmd(CMD_STOP, 8'h00, 1'b0, 0);
  endtask

  task automatic test_long_timing();
    set_timing(16'hFFFF, 16'd15, 16'hFFFF);
    do_cmd(CMD_START, 8'h00, 1'b0, 0);
    do_cmd(CMD_WAITACK, 8'h00, 1'b0, 100);
    set_timing(16'hFFFF, 16'd3, 16'd60);
    do_cmd(CMD_WAITACK, 8'h00, 1'b0, NEVER_ACK);
    set_timing(16'd5, 16'd5, 16'd20);
    do_cmd(CMD_WRITE, 8'($urandom), 1'b0, 0);
    do_cmd(CMD_READ, 8'h00, 1'b1, 0);
  endtask

  task automatic test_backpressure();
    set_timing(16'd1, 16'd2, 16'd8);
    hold_tog <= ~hold_tog;
    i2c_transfer();
    i2c_transfer();
  endtask

  task automatic test_random_transfers(input int n_words);
    int base;
    base = words_sent;
    set_timing(16'($urandom_range(0, 3)), 16'($urandom_range(0, 5)),
               16'($urandom_range(0, 12)));
    while (words_sent - base < n_words) begin
      if ($urandom_range(99) < 15) noise_burst();
      else i2c_transfer();
      if ($urandom_range(99) < 20) begin
        if ($urandom_range(9) == 0)
          set_timing(16'($urandom_range(0, 3)), 16'($urandom_range(0, 5)),
                     16'($urandom_range(13, 300)));
        else
          set_timing(16'($urandom_range(0, 3)), 16'($urandom_range(0, 5)),
                     16'($urandom_range(0, 12)));
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    mode_i       = MODE_TICK;
    write_data_i = '0;
    send_ack_i   = 1'b0;
    sda_in_i     = 1'b1;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_HALF_PERIOD;
    cfg_data_i   = '0;
    reset_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 35;
    snk_idle_pct = 82;
    test_basic_commands();
    test_random_transfers(150);

    src_idle_pct = 82;
    snk_idle_pct = 35;
    test_min_timing();
    test_random_transfers(150);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_long_timing();
    test_backpressure();
    test_random_transfers(150);

    in_valid_i <= 1'b0;
    while (line_status_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("i2c_bit_level_master_core verification clean");
    else
      $display("i2c_bit_level_master_core verification failed");
    $finish;
  end

endmodule
